@@ rtl/cpf_pkg.sv @@
// Types and constants shared by the pointer filter.
package cpf_pkg;

  localparam logic [63:0] HASH_MULT = 64'd2654435761;
  localparam int unsigned PTR_BYTES = 8;
  localparam int unsigned PTR_LSB = $clog2(PTR_BYTES);
  localparam int unsigned ADDR_W = 64;
  localparam logic [7:0] HDR_BYTES_RESET = 8'd16;

  typedef enum logic [1:0] {
    KIND_TRACK   = 2'd0,
    KIND_UNTRACK = 2'd1,
    KIND_PROBE   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2,
    STAT_BAD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_EVAL
  } state_t;

endpackage

@@ rtl/conservative_pointer_filter.sv @@
// Top level of the pointer filter: hashed set-associative table of tracked header addresses.
//
// After reset the block sweeps the valid store, one bucket per cycle, over all buckets with
// busy high; configuration writes are taken during that time. An item of kind track, untrack
// or probe is taken when start is high and busy is low; its result appears on the out_ ports
// with out_valid high for one cycle, after states S_LOOK and S_EVAL and the output register;
// busy drops in that same cycle, so no new item is taken until the last is through the row
// read (hash, synchronous read, compare and write back). Kind 3 is taken in idle and gives
// no result. The receiver cannot stall: each result beat is shown for exactly one cycle.
module conservative_pointer_filter
  import cpf_pkg::*;
#(
  parameter int unsigned TABLE_BITS = 12,
  parameter int unsigned WAYS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_kind,
  input  logic [ADDR_W-1:0]   in_address,
  output logic                out_valid,
  output logic                out_hit,
  output logic [ADDR_W-1:0]   out_header_address,
  output logic [1:0]          out_status
);

  localparam int unsigned BUCKETS = 1 << TABLE_BITS;
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ROW_W = WAYS * ADDR_W;

  logic [WAYS-1:0]  valid_mem [BUCKETS];
  logic [ROW_W-1:0] addr_mem  [BUCKETS];

  state_t state_r, state_nxt;
  logic [TABLE_BITS-1:0] clr_r;
  logic [7:0] hdr_bytes_r;
  kind_t kind_r;
  logic [ADDR_W-1:0] key_r;
  logic bad_r;
  logic [TABLE_BITS-1:0] bucket_r;
  logic [WAYS-1:0] vrow_r;
  logic [ROW_W-1:0] arow_r;

  logic out_valid_r, out_hit_r;
  logic [ADDR_W-1:0] out_hdr_r;
  status_t out_status_r;

  logic accept;
  kind_t in_kind_t;
  logic [TABLE_BITS-1:0] hash_key, hash_mul, bucket;
  logic [2*TABLE_BITS-1:0] hash_prod;

  logic [WAYS-1:0] match, free;
  logic match_any, free_any;
  logic [WAY_W-1:0] match_way, free_way;

  logic vwe, awe;
  logic [TABLE_BITS-1:0] vwa;
  logic [WAYS-1:0] vwd;
  logic [ROW_W-1:0] awd;
  logic res_hit;
  logic [ADDR_W-1:0] res_hdr;
  status_t res_status;

  assign in_kind_t = kind_t'(in_kind);
  assign accept = start && !busy;

  assign hash_key = key_r[4 +: TABLE_BITS];
  assign hash_mul = HASH_MULT[TABLE_BITS-1:0];
  assign hash_prod = hash_key * hash_mul;
  assign bucket = hash_prod[TABLE_BITS-1:0];

  always_comb begin
    match = '0;
    free = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = vrow_r[w] && (arow_r[w*ADDR_W +: ADDR_W] == key_r);
      free[w] = !vrow_r[w];
    end
  end

  always_comb begin
    match_way = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) match_way = WAY_W'(w);
      if (free[w]) free_way = WAY_W'(w);
    end
  end

  assign match_any = |match;
  assign free_any = |free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: if (start && in_kind_t != KIND_NONE) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != S_IDLE);
    vwe = 1'b0;
    awe = 1'b0;
    vwa = bucket_r;
    vwd = vrow_r;
    awd = arow_r;
    res_hit = 1'b0;
    res_hdr = key_r;
    res_status = STAT_OK;
    unique case (state_r)
      S_CLEAR: begin
        vwe = 1'b1;
        vwa = clr_r;
        vwd = '0;
      end
      S_EVAL: begin
        unique case (kind_r)
          KIND_TRACK: begin
            if (free_any) begin
              vwe = 1'b1;
              awe = 1'b1;
              vwd[free_way] = 1'b1;
              awd[free_way*ADDR_W +: ADDR_W] = key_r;
            end else begin
              res_status = STAT_FULL;
            end
          end
          KIND_UNTRACK: begin
            if (match_any) begin
              vwe = 1'b1;
              vwd[match_way] = 1'b0;
              res_hit = 1'b1;
            end else begin
              res_status = STAT_MISS;
            end
          end
          KIND_PROBE: begin
            if (bad_r) begin
              res_status = STAT_BAD;
              res_hdr = '0;
            end else if (match_any) begin
              res_hit = 1'b1;
            end else begin
              res_status = STAT_MISS;
            end
          end
          default: res_status = STAT_OK;
        endcase
      end
      default: vwe = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vwe) valid_mem[vwa] <= vwd;
    if (awe) addr_mem[bucket_r] <= awd;
    vrow_r <= valid_mem[bucket];
    arow_r <= addr_mem[bucket];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      hdr_bytes_r <= HDR_BYTES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_we) hdr_bytes_r <= cfg_wdata;
      out_valid_r <= (state_r == S_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind_t;
      if (in_kind_t == KIND_PROBE) begin
        key_r <= in_address - {{(ADDR_W-8){1'b0}}, hdr_bytes_r};
      end else begin
        key_r <= in_address;
      end
      bad_r <= (in_kind_t == KIND_PROBE) &&
               ((in_address == '0) || (in_address[PTR_LSB-1:0] != '0));
    end
    if (state_r == S_LOOK) bucket_r <= bucket;
    if (state_r == S_EVAL) begin
      out_hit_r <= res_hit;
      out_hdr_r <= res_hdr;
      out_status_r <= res_status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit = out_hit_r;
  assign out_header_address = out_hdr_r;
  assign out_status = out_status_r;

endmodule

@@ tb/sv/tb_conservative_pointer_filter.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for conservative_pointer_filter: directed cases, then random beats.
module tb_conservative_pointer_filter
  import cpf_pkg::*;
();

  localparam int unsigned TBL_BITS = 12;
  localparam int unsigned NWAYS = 4;
  localparam int unsigned SLOTS = (1 << TBL_BITS) * NWAYS;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned SETTLE_CYC = 4;
  localparam int unsigned PHASE_ITEMS = 320;

  typedef struct {
    logic        hit;
    logic [63:0] hdr;
    status_t     st;
  } filter_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = KIND_NONE;
  logic [63:0] in_address = 64'd0;
  logic        out_valid;
  logic        out_hit;
  logic [63:0] out_header_address;
  logic [1:0]  out_status;

  logic [63:0]    slot_addr [SLOTS];
  bit             slot_vld [SLOTS];
  logic [7:0]     hdr_bytes_mdl = HDR_BYTES_RESET;
  filter_result_t pending_results [$];
  int unsigned    err_cnt = 0;
  int unsigned    quiet_cyc = 0;
  logic [63:0]    cluster_base [8];
  int             burst_left = 0;

  conservative_pointer_filter #(
    .TABLE_BITS(TBL_BITS),
    .WAYS(NWAYS)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_address(in_address),
    .out_valid(out_valid),
    .out_hit(out_hit),
    .out_header_address(out_header_address),
    .out_status(out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned hash_bucket(input logic [63:0] a);
    logic [63:0] prod;
    prod = (a >> 4) * HASH_MULT;
    return int'(prod[TBL_BITS-1:0]);
  endfunction

  function automatic int find_way(input logic [63:0] a);
    int unsigned base;
    base = hash_bucket(a) * NWAYS;
    for (int w = 0; w < NWAYS; w++) begin
      if (slot_vld[base + w] && slot_addr[base + w] == a) return base + w;
    end
    return -1;
  endfunction

  function automatic void predict_result(input logic [1:0] k, input logic [63:0] a);
    filter_result_t r;
    int unsigned    base;
    int             s;
    r.hit = 1'b0;
    r.hdr = 64'd0;
    r.st = STAT_OK;
    case (k)
      KIND_TRACK: begin
        base = hash_bucket(a) * NWAYS;
        s = -1;
        for (int w = 0; w < NWAYS; w++) begin
          if (s < 0 && !slot_vld[base + w]) s = base + w;
        end
        r.hdr = a;
        if (s >= 0) begin
          slot_vld[s] = 1'b1;
          slot_addr[s] = a;
        end else begin
          r.st = STAT_FULL;
        end
      end
      KIND_UNTRACK: begin
        s = find_way(a);
        r.hdr = a;
        if (s >= 0) begin
          slot_vld[s] = 1'b0;
          r.hit = 1'b1;
        end else begin
          r.st = STAT_MISS;
        end
      end
      KIND_PROBE: begin
        if (a == 64'd0 || a[PTR_LSB-1:0] != '0) begin
          r.st = STAT_BAD;
        end else begin
          r.hdr = a - {56'd0, hdr_bytes_mdl};
          if (find_way(r.hdr) >= 0) r.hit = 1'b1;
          else r.st = STAT_MISS;
        end
      end
      default: return;
    endcase
    pending_results.push_back(r);
  endfunction

  // Leaves start high so back-to-back beats stay back-to-back.
  task automatic send_beat(input kind_t k, input logic [63:0] a);
    start <= 1'b1;
    in_kind <= k;
    in_address <= a;
    do @(posedge clk); while (busy);
    predict_result(k, a);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_header_bytes(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    hdr_bytes_mdl = v;
  endtask

  task automatic test_basic_lookup();
    logic [63:0] a;
    a = 64'h0000_1000_0000_2340;
    send_beat(KIND_TRACK, a);
    send_beat(KIND_PROBE, a + 64'd16);
    send_beat(KIND_PROBE, a + 64'd24);
    send_beat(KIND_PROBE, 64'd0);
    send_beat(KIND_PROBE, a + 64'd17);
    send_beat(KIND_PROBE, a + 64'd20);
    send_beat(KIND_UNTRACK, a);
    send_beat(KIND_UNTRACK, a);
    send_beat(KIND_PROBE, a + 64'd16);
    send_beat(KIND_NONE, rand64());
  endtask

  task automatic test_duplicate_track();
    logic [63:0] b;
    b = 64'h0000_2222_0000_0a50;
    send_beat(KIND_TRACK, b);
    send_beat(KIND_TRACK, b);
    send_beat(KIND_UNTRACK, b);
    send_beat(KIND_UNTRACK, b);
    send_beat(KIND_UNTRACK, b);
  endtask

  // Offsets above bit 15 leave the bucket index unchanged.
  task automatic test_full_bucket();
    logic [63:0] c;
    c = 64'h0000_3300_0000_0770;
    for (int k = 0; k < 5; k++) send_beat(KIND_TRACK, c + (64'(k) << 16));
    send_beat(KIND_PROBE, c + (64'd4 << 16) + 64'd16);
    send_beat(KIND_UNTRACK, c + (64'd1 << 16));
    send_beat(KIND_TRACK, c + (64'd4 << 16));
    send_beat(KIND_PROBE, c + (64'd4 << 16) + 64'd16);
  endtask

  task automatic test_wrap_and_extremes();
    send_beat(KIND_TRACK, 64'hffff_ffff_ffff_fff8);
    send_beat(KIND_PROBE, 64'd8);
    send_beat(KIND_PROBE, 64'hffff_ffff_ffff_ffff);
    send_beat(KIND_PROBE, 64'hffff_ffff_ffff_fff8);
    send_beat(KIND_TRACK, 64'hffff_ffff_ffff_ffff);
    send_beat(KIND_UNTRACK, 64'hffff_ffff_ffff_ffff);
  endtask

  task automatic test_header_bytes_extremes();
    drain();
    set_header_bytes(8'd0);
    send_beat(KIND_TRACK, 64'h0000_7fff_0000_1000);
    send_beat(KIND_PROBE, 64'h0000_7fff_0000_1000);
    drain();
    set_header_bytes(8'd255);
    send_beat(KIND_TRACK, 64'h0000_7fff_0000_2001);
    send_beat(KIND_PROBE, 64'h0000_7fff_0000_2100);
    send_beat(KIND_PROBE, 64'd248);
  endtask

  task automatic test_random_traffic();
    logic [7:0]  phase_hb [5];
    int unsigned sel;
    logic [63:0] addr;
    logic [63:0] word;
    phase_hb = '{8'd0, 8'd255, 8'($urandom), 8'd8, 8'($urandom)};
    for (int p = 0; p < 5; p++) begin
      drain();
      set_header_bytes(phase_hb[p]);
      // clustered headers whose payload pointers are aligned under this header size
      for (int i = 0; i < 8; i++) begin
        cluster_base[i] = (rand64() & ~64'd7) - {56'd0, phase_hb[p]};
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
        end
        burst_left--;
        sel = $urandom_range(0, 99);
        addr = cluster_base[$urandom_range(0, 7)] + (64'($urandom_range(0, 7)) << 16);
        if (sel < 30) begin
          send_beat(KIND_TRACK, ($urandom_range(0, 3) == 0) ? rand64() : addr);
        end else if (sel < 50) begin
          send_beat(KIND_UNTRACK, ($urandom_range(0, 4) == 0) ? rand64() : addr);
        end else if (sel < 80) begin
          send_beat(KIND_PROBE, addr + {56'd0, hdr_bytes_mdl});
        end else if (sel < 95) begin
          case ($urandom_range(0, 3))
            0: word = 64'd0;
            1: word = rand64();
            2: word = rand64() & ~64'd7;
            default: word = 64'($urandom_range(1, 31)) << 3;
          endcase
          send_beat(KIND_PROBE, word);
        end else begin
          send_beat(KIND_NONE, rand64());
        end
      end
    end
  endtask

  always @(posedge clk) begin
    filter_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: header_address %h", out_header_address);
        err_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (out_hit !== e.hit) begin
          $error("hit: expected %0b actual %0b", e.hit, out_hit);
          err_cnt++;
        end
        if (out_header_address !== e.hdr) begin
          $error("header_address: expected %h actual %h", e.hdr, out_header_address);
          err_cnt++;
        end
        if (out_status !== e.st) begin
          $error("status: expected %0d actual %0d", e.st, out_status);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= IDLE_LIMIT) begin
      $display("tb_conservative_pointer_filter NOT OK");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_lookup();
    test_duplicate_track();
    test_full_bucket();
    test_wrap_and_extremes();
    test_header_bytes_extremes();
    test_random_traffic();
    drain();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_conservative_pointer_filter OK");
    end else begin
      $display("tb_conservative_pointer_filter NOT OK");
    end
    $finish;
  end

endmodule
